// File: rtl/core/toq_pkg.sv
// ----------------------------------------------------------------------------
// toq_pkg: shared types and codes for the overlay queue
// Words on the command and result channels, cell entries, cell control
// and the command, result-kind and cell-operation codes, and the type-mask test.
// ----------------------------------------------------------------------------
`default_nettype none

package toq_pkg;

  localparam int HANDLE_BITS = 16;

  // Command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_MARKER   = 3'd0;
  localparam logic [2:0] KIND_RELEASED = 3'd1;
  localparam logic [2:0] KIND_EVICTED  = 3'd2;
  localparam logic [2:0] KIND_CLEARED  = 3'd3;
  localparam logic [2:0] KIND_DROPPED  = 3'd4;

  // Cell operations, broadcast to every cell of a chain
  localparam logic [1:0] OP_HOLD        = 2'd0;
  localparam logic [1:0] OP_INSERT      = 2'd1;  // sorted insert, or append for the FIFO
  localparam logic [1:0] OP_INSERT_FULL = 2'd2;  // insert into a full list, head drops out
  localparam logic [1:0] OP_ROTATE      = 2'd3;  // shift toward head, head to tail if kept

  // Command word
  typedef struct packed {
    logic [1:0]             command;
    logic [31:0]            timestamp;
    logic [HANDLE_BITS-1:0] handle;
    logic [1:0]             overlay_type;
    logic                   untimed;
    logic [2:0]             type_mask;
  } toq_item_t;

  // Result word
  typedef struct packed {
    logic [2:0]             kind;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [1:0]             out_type;
    logic                   last;
  } toq_result_t;

  // Entry of a timed cell
  typedef struct packed {
    logic [31:0]            key;
    logic [HANDLE_BITS-1:0] handle;
    logic [1:0]             otype;
  } toq_tentry_t;

  // Entry of a FIFO cell
  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [1:0]             otype;
  } toq_fentry_t;

  // Control broadcast along a chain
  typedef struct packed {
    logic [1:0]  op;
    logic        keep;
    toq_tentry_t fresh;
  } toq_ctl_t;

  // True when the mask selects the type; type 3 is never selected
  function automatic logic type_hit(input logic [2:0] mask, input logic [1:0] t);
    logic hit;
    unique case (t)
      2'd0:    hit = mask[0];
      2'd1:    hit = mask[1];
      2'd2:    hit = mask[2];
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/toq_timed_cell.sv
// ----------------------------------------------------------------------------
// toq_timed_cell: one slot of the sorted timed list
// Holds key, handle and type; trades entries with its neighbors under the
// broadcast cell operation, and reports whether its key is below the new key.
// ----------------------------------------------------------------------------
`default_nettype none

module toq_timed_cell
  import toq_pkg::*;
(
  input  logic        clk,
  input  toq_ctl_t    ctl,
  input  logic        occ,       // this slot holds an entry
  input  logic        occ_next,  // the slot after this one holds an entry
  input  logic        lt_prev,   // previous slot stays ahead of the new key
  input  logic        lt_next,   // next slot stays ahead of the new key
  input  toq_tentry_t prev,
  input  toq_tentry_t next,
  input  toq_tentry_t head,
  output toq_tentry_t entry,
  output logic        lt
);

  toq_tentry_t entry_next;

  // Flag an occupied entry that sorts ahead of the new key
  assign lt = occ && (entry.key < ctl.fresh.key);

  // Pick the next entry for this slot
  always_comb begin
    entry_next = entry;
    unique case (ctl.op)
      OP_HOLD: begin
        entry_next = entry;
      end
      OP_INSERT: begin
        if (lt) begin
          entry_next = entry;
        end else if (lt_prev) begin
          entry_next = ctl.fresh;
        end else begin
          entry_next = prev;
        end
      end
      OP_INSERT_FULL: begin
        if (lt_next) begin
          entry_next = next;
        end else if (lt) begin
          entry_next = ctl.fresh;
        end
      end
      OP_ROTATE: begin
        if (occ_next) begin
          entry_next = next;
        end else if (occ && ctl.keep) begin
          entry_next = head;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/toq_fifo_cell.sv
// ----------------------------------------------------------------------------
// toq_fifo_cell: one slot of the untimed FIFO
// Takes the new entry when it is the free tail slot, and shifts toward the
// head on release or clear, wrapping a kept head entry to the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module toq_fifo_cell
  import toq_pkg::*;
(
  input  logic        clk,
  input  toq_ctl_t    ctl,
  input  logic        occ,       // this slot holds an entry
  input  logic        occ_next,  // the slot after this one holds an entry
  input  logic        slot,      // this is the first free slot
  input  toq_fentry_t next,
  input  toq_fentry_t head,
  output toq_fentry_t entry
);

  toq_fentry_t entry_next;

  // Pick the next entry for this slot
  always_comb begin
    entry_next = entry;
    unique case (ctl.op)
      OP_INSERT: begin
        if (slot) begin
          entry_next.handle = ctl.fresh.handle;
          entry_next.otype  = ctl.fresh.otype;
        end
      end
      OP_ROTATE: begin
        if (occ_next) begin
          entry_next = next;
        end else if (occ && ctl.keep) begin
          entry_next = head;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/timestamp_ordered_overlay_queue_unit.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_overlay_queue_unit: overlay presentation queue
// Untimed items wait in a FIFO; timed items sit in a list kept sorted by start
// time. Both stores are rows of cells that shift entries between neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   A command word on item is taken at a clock edge with start high and busy
//   low. busy stays high until the command is finished. Every result word is
//   on result for one cycle with result_strobe high; the receiver cannot hold
//   it off. Each command ends with a marker word (kind 0, last high).
//   enable_overlays is written over cfg_valid/cfg_ready/cfg_data, with
//   cfg_ready always high; write it only while the block is idle.
// Command sequences, from one accepted command to the next:
//   insert   one cell step, then the marker word
//   release  F FIFO items, then K timed items handed out, then the marker
//   clear    F FIFO entries, then T timed entries visited, then the marker
//   Release and clear move one entry per cycle past the head cell of each
//   chain; that single head port sets the rate.
// Reset clears both fill counts and the enable register; stored entries are
//   not cleared and are never read above the fill counts.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_ordered_overlay_queue_unit
  import toq_pkg::*;
#(
  parameter int TIMED_DEPTH = 32,
  parameter int FIFO_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  toq_item_t   item,
  output logic        result_strobe,
  output toq_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int TCW = $clog2(TIMED_DEPTH + 1);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam int SCW = (TCW > FCW) ? TCW : FCW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_FREL = 3'd2;
  localparam logic [2:0] S_TREL = 3'd3;
  localparam logic [2:0] S_FCLR = 3'd4;
  localparam logic [2:0] S_TCLR = 3'd5;
  localparam logic [2:0] S_MARK = 3'd6;

  logic [2:0]     state, state_next;
  logic [TCW-1:0] tcount, tcount_next;
  logic [FCW-1:0] fcount, fcount_next;
  logic [SCW-1:0] steps, steps_next;
  logic           enable_overlays;
  toq_item_t      req;
  toq_result_t    result_next;
  logic           strobe_next;

  toq_ctl_t       t_ctl, f_ctl;
  toq_tentry_t    tent [TIMED_DEPTH];
  toq_fentry_t    fent [FIFO_DEPTH];
  logic [TIMED_DEPTH-1:0] t_occ, t_lt;
  logic [FIFO_DEPTH-1:0]  f_occ, f_slot;
  logic           f_hit, t_hit;
  logic           t_head_lt;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Timed chain
  for (genvar i = 0; i < TIMED_DEPTH; i++) begin : g_tcell
    logic        occ_next, lt_prev, lt_next;
    toq_tentry_t prev_e, next_e;

    assign t_occ[i] = (TCW'(i) < tcount);

    if (i == 0) begin : g_first
      assign lt_prev = 1'b1;
      assign prev_e  = t_ctl.fresh;
    end else begin : g_mid
      assign lt_prev = t_lt[i-1];
      assign prev_e  = tent[i-1];
    end

    if (i == TIMED_DEPTH - 1) begin : g_last
      assign occ_next = 1'b0;
      assign lt_next  = 1'b0;
      assign next_e   = tent[i];
    end else begin : g_inner
      assign occ_next = t_occ[i+1];
      assign lt_next  = t_lt[i+1];
      assign next_e   = tent[i+1];
    end

    toq_timed_cell u_cell (
      .clk      (clk),
      .ctl      (t_ctl),
      .occ      (t_occ[i]),
      .occ_next (occ_next),
      .lt_prev  (lt_prev),
      .lt_next  (lt_next),
      .prev     (prev_e),
      .next     (next_e),
      .head     (tent[0]),
      .entry    (tent[i]),
      .lt       (t_lt[i])
    );
  end

  // FIFO chain
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_fcell
    logic        occ_next;
    toq_fentry_t next_e;

    assign f_occ[i]  = (FCW'(i) < fcount);
    assign f_slot[i] = (FCW'(i) == fcount);

    if (i == FIFO_DEPTH - 1) begin : g_last
      assign occ_next = 1'b0;
      assign next_e   = fent[i];
    end else begin : g_inner
      assign occ_next = f_occ[i+1];
      assign next_e   = fent[i+1];
    end

    toq_fifo_cell u_cell (
      .clk      (clk),
      .ctl      (f_ctl),
      .occ      (f_occ[i]),
      .occ_next (occ_next),
      .slot     (f_slot[i]),
      .next     (next_e),
      .head     (fent[0]),
      .entry    (fent[i])
    );
  end

  assign f_hit = type_hit(req.type_mask, fent[0].otype);
  assign t_hit = type_hit(req.type_mask, tent[0].otype);

  // Compare the head entry with the held key
  assign t_head_lt = t_occ[0] && (tent[0].key < req.timestamp);

  // Sequence the command and drive both chains
  always_comb begin
    state_next   = state;
    tcount_next  = tcount;
    fcount_next  = fcount;
    steps_next   = steps;
    strobe_next  = 1'b0;
    result_next  = '0;
    t_ctl.op     = OP_HOLD;
    t_ctl.keep   = 1'b0;
    t_ctl.fresh.key    = req.timestamp;
    t_ctl.fresh.handle = req.handle;
    t_ctl.fresh.otype  = req.overlay_type;
    f_ctl        = t_ctl;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (item.command)
            CMD_INSERT: begin
              state_next = S_INS;
            end
            CMD_RELEASE: begin
              state_next = S_FREL;
            end
            CMD_CLEAR: begin
              state_next = S_FCLR;
              steps_next = SCW'(fcount);
            end
            default: begin
              state_next = S_MARK;
            end
          endcase
        end
      end

      S_INS: begin
        state_next = S_MARK;
        if (!enable_overlays) begin
          strobe_next = 1'b1;
          result_next = '{kind: KIND_DROPPED, out_handle: req.handle,
                          out_type: req.overlay_type, last: 1'b0};
        end else if (req.untimed) begin
          if (fcount == FCW'(FIFO_DEPTH)) begin
            strobe_next = 1'b1;
            result_next = '{kind: KIND_DROPPED, out_handle: req.handle,
                            out_type: req.overlay_type, last: 1'b0};
          end else begin
            f_ctl.op    = OP_INSERT;
            fcount_next = fcount + FCW'(1);
          end
        end else if (tcount == TCW'(TIMED_DEPTH)) begin
          strobe_next = 1'b1;
          if (!t_head_lt) begin
            // new item sorts first: it is the one evicted
            result_next = '{kind: KIND_EVICTED, out_handle: req.handle,
                            out_type: req.overlay_type, last: 1'b0};
          end else begin
            t_ctl.op    = OP_INSERT_FULL;
            result_next = '{kind: KIND_EVICTED, out_handle: tent[0].handle,
                            out_type: tent[0].otype, last: 1'b0};
          end
        end else begin
          t_ctl.op    = OP_INSERT;
          tcount_next = tcount + TCW'(1);
        end
      end

      S_FREL: begin
        if (fcount != '0) begin
          f_ctl.op    = OP_ROTATE;
          fcount_next = fcount - FCW'(1);
          strobe_next = 1'b1;
          result_next = '{kind: KIND_RELEASED, out_handle: fent[0].handle,
                          out_type: fent[0].otype, last: 1'b0};
        end else begin
          state_next = S_TREL;
        end
      end

      S_TREL: begin
        if (tcount != '0 && tent[0].key <= req.timestamp) begin
          t_ctl.op    = OP_ROTATE;
          tcount_next = tcount - TCW'(1);
          strobe_next = 1'b1;
          result_next = '{kind: KIND_RELEASED, out_handle: tent[0].handle,
                          out_type: tent[0].otype, last: 1'b0};
        end else begin
          state_next = S_MARK;
        end
      end

      S_FCLR: begin
        if (steps != '0) begin
          // wrap a kept head to the tail, report a matching one
          f_ctl.op   = OP_ROTATE;
          f_ctl.keep = !f_hit;
          steps_next = steps - SCW'(1);
          if (f_hit) begin
            fcount_next = fcount - FCW'(1);
            strobe_next = 1'b1;
            result_next = '{kind: KIND_CLEARED, out_handle: fent[0].handle,
                            out_type: fent[0].otype, last: 1'b0};
          end
        end else begin
          steps_next = SCW'(tcount);
          state_next = S_TCLR;
        end
      end

      S_TCLR: begin
        if (steps != '0) begin
          t_ctl.op   = OP_ROTATE;
          t_ctl.keep = !t_hit;
          steps_next = steps - SCW'(1);
          if (t_hit) begin
            tcount_next = tcount - TCW'(1);
            strobe_next = 1'b1;
            result_next = '{kind: KIND_CLEARED, out_handle: tent[0].handle,
                            out_type: tent[0].otype, last: 1'b0};
          end
        end else begin
          state_next = S_MARK;
        end
      end

      S_MARK: begin
        strobe_next = 1'b1;
        result_next = '{kind: KIND_MARKER, out_handle: '0, out_type: 2'd0, last: 1'b1};
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tcount          <= '0;
      fcount          <= '0;
      steps           <= '0;
      result_strobe   <= 1'b0;
      enable_overlays <= 1'b0;
    end else begin
      state         <= state_next;
      tcount        <= tcount_next;
      fcount        <= fcount_next;
      steps         <= steps_next;
      result_strobe <= strobe_next;
      if (cfg_valid && cfg_ready) begin
        enable_overlays <= cfg_data;
      end
    end
  end

  // Hold the command word and the outgoing result word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= item;
    end
    result <= result_next;
  end

endmodule

`default_nettype wire
